// ===== hdl/spfl_pkg.sv =====
// Shared types and constants of the slot pool free-list allocator.
// Field widths, command, status and register codes, and parameter defaults.
// Depends on nothing; every other file imports it.
package spfl_pkg;

   localparam int DEF_MAX_SLOTS = 256;
   localparam int DEF_GEN_BITS  = 16;

   localparam int SLOT_FIELD_W = 8;
   localparam int GEN_FIELD_W  = 16;
   localparam int OFFSET_W     = 20;
   localparam int STATUS_W     = 2;
   localparam int SIU_W        = 9;
   localparam int BYTES_W      = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int RSP_DATA_W   = 48;

   localparam logic [SIU_W-1:0]   SIU_RESET   = 9'd256;
   localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd64;

   localparam logic CMD_GET    = 1'b0;
   localparam logic CMD_RETURN = 1'b1;

   localparam logic CSR_SLOTS_IN_USE = 1'b0;
   localparam logic CSR_SLOT_BYTES   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef enum logic [3:0] {
      FSM_IDLE = 4'b0001,
      FSM_SLOT = 4'b0010,
      FSM_GEN  = 4'b0100,
      FSM_DONE = 4'b1000
   } fsm_type;

endpackage

// ===== hdl/spfl_gen_table.sv =====
// Generation counter memory of the slot pool allocator, one entry per slot.
// Clears itself after reset in a sweep of one entry per cycle.
// Depends on spfl_pkg for the parameter defaults.
module spfl_gen_table
   import spfl_pkg::*;
#(
   parameter int MAX_SLOTS = DEF_MAX_SLOTS,
   parameter int GEN_BITS  = DEF_GEN_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_SLOTS)-1:0] rd_addr,
   output logic [GEN_BITS-1:0]          rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_SLOTS)-1:0] wr_addr,
   input  logic [GEN_BITS-1:0]          wr_data,
   output logic                         busy
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);

   logic [GEN_BITS-1:0] gen_mem [MAX_SLOTS];
   logic [GEN_BITS-1:0] rd_q_ff;
   logic                clear_ff;
   logic                clear_in;
   logic [SLOT_W-1:0]   sweep_ff;
   logic [SLOT_W-1:0]   sweep_in;

   always_comb begin
      clear_in = clear_ff;
      sweep_in = sweep_ff;
      if (clear_ff) begin
         sweep_in = sweep_ff + 1'b1;
         if (sweep_ff == SLOT_W'(MAX_SLOTS - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         sweep_ff <= '0;
      end else begin
         clear_ff <= clear_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         gen_mem[sweep_ff] <= '0;
      end else if (wr_en) begin
         gen_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= gen_mem[rd_addr];
      end
   end

   assign rd_data = rd_q_ff;
   assign busy    = clear_ff;

endmodule

// ===== hdl/slot_pool_free_list_allocator.sv =====
// Slot pool allocator: a free-list stack in memory and a generation counter per slot.
// Top level; holds the free-stack memory and the command sequencer.
// Depends on spfl_pkg and spfl_gen_table.
//
// The block takes one item at a time. A return, or a get from an empty pool, goes
// from acceptance straight to FSM_DONE, which loads the output register once it is free.
// A successful get passes through FSM_SLOT and FSM_GEN first; the read of the free-stack
// memory is followed by the dependent read and write-back of the generation memory. The
// next item is accepted once the previous result has moved into the output register, so
// one result waiting at the output does not hold off the next item, but a second one
// does. After reset the generation memory is cleared in a sweep over its MAX_SLOTS
// entries, during which req_tready stays low; configuration writes are taken at any
// time. Writing the pool size reloads the free list at once, without a sweep.
module slot_pool_free_list_allocator
   import spfl_pkg::*;
#(
   parameter int MAX_SLOTS = DEF_MAX_SLOTS,
   parameter int GEN_BITS  = DEF_GEN_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SLOT_FIELD_W-1:0] req_tdata,   // [7:0] returned_slot
   input  logic                    req_tuser,   // [0] command
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [7:0] slot_index, [23:8] generation,
                                                // [43:24] slot_offset, [47:44] zero
   output logic [STATUS_W-1:0]     rsp_tuser,   // [1:0] status
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int PROD_W = SLOT_W + BYTES_W;

   function automatic logic [CNT_W-1:0] pool_clamp(input logic [SIU_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (32'(v) > 32'(MAX_SLOTS)) begin
         r = CNT_W'(MAX_SLOTS);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   fsm_type                 state_ff, state_in;
   logic [CNT_W-1:0]        pool_ff, pool_in;
   logic [BYTES_W-1:0]      bytes_ff, bytes_in;
   logic [CNT_W-1:0]        fc_ff, fc_in;
   logic [CNT_W-1:0]        low_ff, low_in;
   logic                    prist_ff, prist_in;
   logic [SLOT_W-1:0]       pval_ff, pval_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [SLOT_FIELD_W-1:0] res_slot_ff, res_slot_in;
   logic [GEN_FIELD_W-1:0]  res_gen_ff, res_gen_in;
   logic [OFFSET_W-1:0]     res_off_ff, res_off_in;
   logic [STATUS_W-1:0]     res_stat_ff, res_stat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]     rsp_user_ff, rsp_user_in;

   logic [SLOT_W-1:0]   stack_mem [MAX_SLOTS];
   logic [SLOT_W-1:0]   stack_q_ff;
   logic                stack_re;
   logic [SLOT_W-1:0]   stack_raddr;
   logic                stack_we;
   logic [SLOT_W-1:0]   stack_waddr;
   logic [SLOT_W-1:0]   stack_wdata;

   logic                gen_rd_en;
   logic [SLOT_W-1:0]   gen_rd_addr;
   logic [GEN_BITS-1:0] gen_rd_data;
   logic                gen_wr_en;
   logic [GEN_BITS-1:0] gen_new;
   logic                gen_busy;
   logic [PROD_W-1:0]   prod;
   logic [CNT_W-1:0]    fc_dec;

   logic req_acc;
   logic csr_acc;
   logic out_free;

   assign req_tready = (state_ff == FSM_IDLE) && !gen_busy;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_acc    = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign fc_dec  = fc_ff - 1'b1;
   assign gen_new = gen_rd_data + 1'b1;
   assign prod    = PROD_W'(slot_ff) * PROD_W'(bytes_ff);

   always_comb begin
      state_in     = state_ff;
      pool_in      = pool_ff;
      bytes_in     = bytes_ff;
      fc_in        = fc_ff;
      low_in       = low_ff;
      prist_in     = prist_ff;
      pval_in      = pval_ff;
      slot_in      = slot_ff;
      res_slot_in  = res_slot_ff;
      res_gen_in   = res_gen_ff;
      res_off_in   = res_off_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      stack_re     = 1'b0;
      stack_raddr  = fc_dec[SLOT_W-1:0];
      stack_we     = 1'b0;
      stack_waddr  = fc_ff[SLOT_W-1:0];
      stack_wdata  = SLOT_W'(req_tdata);
      gen_rd_en    = 1'b0;
      gen_rd_addr  = slot_ff;
      gen_wr_en    = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (req_acc) begin
               res_gen_in = '0;
               res_off_in = '0;
               if (req_tuser == CMD_GET) begin
                  res_slot_in = '0;
                  if (fc_ff == '0) begin
                     res_stat_in = ST_EMPTY;
                     state_in    = FSM_DONE;
                  end else begin
                     stack_re = 1'b1;
                     prist_in = (fc_ff <= low_ff);
                     pval_in  = SLOT_W'(pool_ff - fc_ff);
                     fc_in    = fc_dec;
                     low_in   = (fc_dec < low_ff) ? fc_dec : low_ff;
                     state_in = FSM_SLOT;
                  end
               end else begin
                  res_slot_in = req_tdata;
                  if (32'(req_tdata) >= 32'(pool_ff)) begin
                     res_stat_in = ST_RANGE;
                  end else if (fc_ff >= pool_ff) begin
                     res_stat_in = ST_FULL;
                  end else begin
                     res_stat_in = ST_OK;
                     stack_we    = 1'b1;
                     fc_in       = fc_ff + 1'b1;
                  end
                  state_in = FSM_DONE;
               end
            end
         end
         FSM_SLOT: begin
            slot_in     = prist_ff ? pval_ff : stack_q_ff;
            gen_rd_en   = 1'b1;
            gen_rd_addr = slot_in;
            state_in    = FSM_GEN;
         end
         FSM_GEN: begin
            gen_wr_en   = 1'b1;
            res_slot_in = SLOT_FIELD_W'(slot_ff);
            res_gen_in  = GEN_FIELD_W'(gen_new);
            res_off_in  = OFFSET_W'(prod);
            res_stat_in = ST_OK;
            state_in    = FSM_DONE;
         end
         FSM_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, res_off_ff, res_gen_ff, res_slot_ff};
               rsp_user_in  = res_stat_ff;
               state_in     = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      if (csr_acc) begin
         if (csr_index == CSR_SLOTS_IN_USE) begin
            pool_in = pool_clamp(csr_data[SIU_W-1:0]);
            fc_in   = pool_clamp(csr_data[SIU_W-1:0]);
            low_in  = pool_clamp(csr_data[SIU_W-1:0]);
         end else begin
            bytes_in = csr_data[BYTES_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pool_ff      <= pool_clamp(SIU_RESET);
         bytes_ff     <= BYTES_RESET;
         fc_ff        <= pool_clamp(SIU_RESET);
         low_ff       <= pool_clamp(SIU_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         bytes_ff     <= bytes_in;
         fc_ff        <= fc_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prist_ff    <= prist_in;
      pval_ff     <= pval_in;
      slot_ff     <= slot_in;
      res_slot_ff <= res_slot_in;
      res_gen_ff  <= res_gen_in;
      res_off_ff  <= res_off_in;
      res_stat_ff <= res_stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Entries below the low-water mark have not been written since the last reload;
   // their slot number is computed from the pool size and the free count instead of the memory.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_q_ff <= stack_mem[stack_raddr];
      end
   end

   spfl_gen_table #(
      .MAX_SLOTS (MAX_SLOTS),
      .GEN_BITS  (GEN_BITS)
   ) u_gen_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (gen_rd_en),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data),
      .wr_en   (gen_wr_en),
      .wr_addr (slot_ff),
      .wr_data (gen_new),
      .busy    (gen_busy)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= pool_ff)
      else $error("free count exceeds pool size");

   a_low_bound: assert property (@(posedge clock) disable iff (reset)
      low_ff <= fc_ff)
      else $error("low-water mark above free count");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stack_we |-> (fc_ff < pool_ff))
      else $error("push into a full free stack");

   a_gen_no_clash: assert property (@(posedge clock) disable iff (reset)
      gen_wr_en |-> !gen_busy)
      else $error("generation write during clearing sweep");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (stack_re && !csr_acc) |=> (fc_ff == $past(fc_dec)) && (state_ff == FSM_SLOT))
      else $error("pop did not decrement the free count");

endmodule
